### sv/hnrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hnrs_pkg;

   localparam int STACK_DEPTH = 8;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int NOTE_W      = 7;
   localparam int COUNT_OUT_W = 4;

   localparam logic ACT_HOLD    = 1'b0;
   localparam logic ACT_RELEASE = 1'b1;

   typedef struct packed {
      logic              valid;
      logic [NOTE_W-1:0] num;
      logic [NOTE_W-1:0] vel;
   } entry_type;

   // Sequencer controls broadcast to every cell.
   typedef struct packed {
      logic              compare;
      logic              shift;
      logic              rel_op;
      logic [NOTE_W-1:0] num;
   } ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMP,
      ST_SHIFT,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

### sv/held_note_recency_stack_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Last-note-priority stack of held notes. Pulse start with a beat (req_action
// hold or release, req_note_num, req_note_vel) while busy is low; the beat is
// taken at that edge and busy rises. Exactly one result beat follows: rsp_strobe
// is high for a single cycle, in the result step that follows the compare and
// shift steps, with the number of notes held and the most recent note (zeros
// when rsp_top_valid is low). The receiver cannot stall, so capture the result
// in that strobe cycle. Each event passes through accept, compare, shift and
// result no matter how deep the stack is; the sequencer runs one broadcast
// compare step and one neighbor shift step over the cell row, and the block
// takes no new beat until the result step is over.
// A hold of a note already held moves it to the top with the new
// velocity; a hold on a full stack drops the oldest note; a release of a note
// not held leaves the stack unchanged. No clearing pass is needed after reset.
module held_note_recency_stack_unit (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           start,
   output logic                          busy,
   input  wire                           req_action,
   input  wire  [hnrs_pkg::NOTE_W-1:0]   req_note_num,
   input  wire  [hnrs_pkg::NOTE_W-1:0]   req_note_vel,
   output logic                          rsp_strobe,
   output logic [hnrs_pkg::COUNT_OUT_W-1:0] rsp_held_count,
   output logic                          rsp_top_valid,
   output logic [hnrs_pkg::NOTE_W-1:0]   rsp_top_num,
   output logic [hnrs_pkg::NOTE_W-1:0]   rsp_top_vel
);
   import hnrs_pkg::*;

   // Sequencer and captured request beat.
   state_type         state_ff;
   state_type         state_in;
   logic              act_ff;
   logic [NOTE_W-1:0] num_ff;
   logic [NOTE_W-1:0] vel_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [CNT_W-1:0]  cnt_in;
   logic              accept;

   // Cell row: cell 0 holds the most recent note, the last cell the oldest.
   ctl_type                ctl;
   entry_type              new_ent;
   entry_type              cell_ent [STACK_DEPTH];
   logic [STACK_DEPTH:0]   seen;
   logic [STACK_DEPTH-1:0] hit_vec;
   logic [STACK_DEPTH-1:0] valid_vec;

   assign accept = start && !busy;

   // Next state: one pass through compare, shift and result per beat.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (start) state_in = ST_CMP;
         ST_CMP:   state_in = ST_SHIFT;
         ST_SHIFT: state_in = ST_RESP;
         ST_RESP:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Outputs and cell controls decoded from the state.
   always_comb begin
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      ctl        = '0;
      ctl.rel_op = (act_ff == ACT_RELEASE);
      ctl.num    = num_ff;
      unique case (state_ff)
         ST_IDLE:  busy = 1'b0;
         ST_CMP:   ctl.compare = 1'b1;
         ST_SHIFT: ctl.shift = 1'b1;
         ST_RESP:  rsp_strobe = 1'b1;
         default:  busy = 1'b1;
      endcase
   end

   // Count follows the shift: a release of a held note drops one, a hold of a
   // new note adds one until the stack is full.
   always_comb begin
      cnt_in = cnt_ff;
      if (state_ff == ST_SHIFT) begin
         if (act_ff == ACT_RELEASE) begin
            if (seen[STACK_DEPTH]) begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end else begin
            if (!seen[STACK_DEPTH] && (cnt_ff != CNT_W'(STACK_DEPTH))) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Capture the request beat; payload needs no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff <= req_action;
         num_ff <= req_note_num;
         vel_ff <= req_note_vel;
      end
   end

   assign new_ent = '{valid: 1'b1, num: num_ff, vel: vel_ff};
   assign seen[0] = 1'b0;

   genvar gi;
   for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
      entry_type prev_ent;
      entry_type next_ent;

      if (gi == 0) begin : g_top
         assign prev_ent = new_ent;
      end else begin : g_mid
         assign prev_ent = cell_ent[gi-1];
      end

      if (gi == STACK_DEPTH - 1) begin : g_tail
         assign next_ent = '0;
      end else begin : g_body
         assign next_ent = cell_ent[gi+1];
      end

      hnrs_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .prev_ent (prev_ent),
         .next_ent (next_ent),
         .seen_in  (seen[gi]),
         .seen_out (seen[gi+1]),
         .hit      (hit_vec[gi]),
         .ent      (cell_ent[gi])
      );

      assign valid_vec[gi] = cell_ent[gi].valid;
   end

   // Result fields come straight from the top cell and the count register,
   // both stable through the result cycle.
   assign rsp_held_count = COUNT_OUT_W'(cnt_ff);
   assign rsp_top_valid  = cell_ent[0].valid;
   assign rsp_top_num    = cell_ent[0].valid ? cell_ent[0].num : '0;
   assign rsp_top_vel    = cell_ent[0].valid ? cell_ent[0].vel : '0;

   // Live entries stay packed against the top and match the count.
   a_count_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(cnt_ff))
      else $error("cell valid bits disagree with count");

   // Notes are unique, so at most one cell flags a match.
   a_single_hit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT) |-> $onehot0(hit_vec))
      else $error("more than one cell matched the note");

   // A result beat comes only right after the shift step.
   a_strobe_after_shift: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(state_ff) == ST_SHIFT))
      else $error("result strobe without a shift step");

   // An accepted beat always yields a result beat, after the compare and shift steps.
   a_accept_to_strobe: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##2 rsp_strobe)
      else $error("accepted beat produced no result");

   // After a hold the new note sits on top.
   a_hold_on_top: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (act_ff == ACT_HOLD)) |->
         (rsp_top_valid && (rsp_top_num == num_ff) && (rsp_top_vel == vel_ff)))
      else $error("held note not on top");

endmodule

`default_nettype wire

### sv/hnrs_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module hnrs_cell (
   input  wire                      clock,
   input  wire                      reset,
   input  wire hnrs_pkg::ctl_type   ctl,
   input  wire hnrs_pkg::entry_type prev_ent,
   input  wire hnrs_pkg::entry_type next_ent,
   input  wire                      seen_in,
   output logic                     seen_out,
   output logic                     hit,
   output hnrs_pkg::entry_type      ent
);
   import hnrs_pkg::*;

   entry_type ent_ff;
   entry_type ent_in;
   logic      hit_ff;
   logic      hit_in;

   // Flag a match on a live entry during the compare step, hold it otherwise.
   always_comb begin
      hit_in = hit_ff;
      if (ctl.compare) begin
         hit_in = ent_ff.valid && (ent_ff.num == ctl.num);
      end
   end

   // Hold: take the newer neighbor's entry unless the match lies closer to the top.
   // Release: take the older neighbor's entry from the match downward.
   always_comb begin
      ent_in = ent_ff;
      if (ctl.shift) begin
         if (ctl.rel_op) begin
            if (seen_out) begin
               ent_in = next_ent;
            end
         end else begin
            if (!seen_in) begin
               ent_in = prev_ent;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_ff <= '0;
         hit_ff <= 1'b0;
      end else begin
         ent_ff <= ent_in;
         hit_ff <= hit_in;
      end
   end

   assign seen_out = seen_in | hit_ff;
   assign hit      = hit_ff;
   assign ent      = ent_ff;

endmodule

`default_nettype wire
